FILE: hdl/ctk_pkg.sv
// Shared types, codes and character classes for the C source tokenizer.
package ctk_pkg;

  localparam int MAX_LEN    = 4095;
  localparam int LINE_BITS  = 24;
  localparam logic [23:0] LINE_MAX = 24'((64'd1 << LINE_BITS) - 64'd1);
  localparam logic [15:0] COL_MAX  = 16'hFFFF;
  localparam int FIFO_DEPTH = 8;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_SLASH  = 4'd1;
  localparam logic [3:0] M_LCOM   = 4'd2;
  localparam logic [3:0] M_BCOM   = 4'd3;
  localparam logic [3:0] M_BSTAR  = 4'd4;
  localparam logic [3:0] M_IDENT  = 4'd5;
  localparam logic [3:0] M_NUM    = 4'd6;
  localparam logic [3:0] M_SUFFIX = 4'd7;
  localparam logic [3:0] M_STR    = 4'd8;
  localparam logic [3:0] M_CHAR   = 4'd9;
  localparam logic [3:0] M_P1     = 4'd10;
  localparam logic [3:0] M_P2     = 4'd11;
  localparam logic [3:0] M_DOT    = 4'd12;

  localparam logic [5:0] K_UNKNOWN       = 6'd0;
  localparam logic [5:0] K_NUMBER        = 6'd1;
  localparam logic [5:0] K_STRING        = 6'd2;
  localparam logic [5:0] K_CHAR          = 6'd3;
  localparam logic [5:0] K_IDENT         = 6'd4;
  localparam logic [5:0] K_DIV           = 6'd8;
  localparam logic [5:0] K_DIV_ASSIGN    = 6'd13;
  localparam logic [5:0] K_LSHIFT        = 6'd31;
  localparam logic [5:0] K_RSHIFT        = 6'd32;
  localparam logic [5:0] K_LSHIFT_ASSIGN = 6'd37;
  localparam logic [5:0] K_RSHIFT_ASSIGN = 6'd38;
  localparam logic [5:0] K_DOT           = 6'd45;
  localparam logic [5:0] K_ELLIPSIS      = 6'd50;
  localparam logic [5:0] K_EOF           = 6'd52;
  localparam logic [5:0] K_ERROR         = 6'd53;

  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] len;
    logic [63:0] value;
    logic [23:0] line;
    logic [15:0] col;
    logic        last;
  } tok_t;

  typedef tok_t [2:0] tok_arr_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h0A || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
  endfunction

  // 16 marks a non-hex byte
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd16;
    if (is_digit(b)) t = b - 8'h30;
    else if (b >= "a" && b <= "f") t = b - 8'h57;
    else if (b >= "A" && b <= "F") t = b - 8'h37;
    return t[4:0];
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "(": k = 6'd39;
      ")": k = 6'd40;
      "[": k = 6'd41;
      "]": k = 6'd42;
      "{": k = 6'd43;
      "}": k = 6'd44;
      ";": k = 6'd47;
      ":": k = 6'd48;
      ",": k = 6'd49;
      "?": k = 6'd51;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] lone_kind(input logic [7:0] h);
    logic [5:0] k;
    case (h)
      "+": k = 6'd5;
      "-": k = 6'd6;
      "*": k = 6'd7;
      "%": k = 6'd9;
      "=": k = 6'd17;
      ">": k = 6'd18;
      "<": k = 6'd19;
      "!": k = 6'd24;
      "&": k = 6'd27;
      "~": k = 6'd28;
      "|": k = 6'd29;
      "^": k = 6'd30;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
    logic [5:0] k;
    k = K_UNKNOWN;
    if (b == "=") begin
      case (h)
        "+": k = 6'd10;
        "-": k = 6'd11;
        "*": k = 6'd12;
        "%": k = 6'd14;
        "=": k = 6'd22;
        ">": k = 6'd20;
        "<": k = 6'd21;
        "!": k = 6'd23;
        "&": k = 6'd33;
        "~": k = 6'd34;
        "|": k = 6'd35;
        "^": k = 6'd36;
        default: k = K_UNKNOWN;
      endcase
    end else if (h == b) begin
      case (h)
        "+": k = 6'd15;
        "-": k = 6'd16;
        "&": k = 6'd25;
        "|": k = 6'd26;
        default: k = K_UNKNOWN;
      endcase
    end else if (h == "-" && b == ">") begin
      k = 6'd46;
    end
    return k;
  endfunction

  function automatic logic [15:0] col_inc(input logic [15:0] c);
    return (c < COL_MAX) ? c + 16'd1 : COL_MAX;
  endfunction

  function automatic tok_t mk(input logic [5:0] kind, input logic [12:0] len,
                              input logic [63:0] value, input logic [23:0] line,
                              input logic [15:0] col);
    tok_t t;
    t.kind  = kind;
    t.len   = (len > 13'(MAX_LEN)) ? 12'(MAX_LEN) : len[11:0];
    t.value = value;
    t.line  = line;
    t.col   = col;
    t.last  = 1'b0;
    return t;
  endfunction

  // appends a token unless three are already queued for this byte
  function automatic tok_arr_t put(input tok_arr_t q, input logic [1:0] n, input tok_t t);
    tok_arr_t r;
    r = q;
    if (n != 2'd3) r[n] = t;
    return r;
  endfunction

  function automatic logic [1:0] cnt_inc(input logic [1:0] n);
    return (n != 2'd3) ? n + 2'd1 : n;
  endfunction

endpackage

FILE: hdl/ctk_scan.sv
// Lexer state registers and the per-byte next-state and token logic.
module ctk_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        b,
  input  logic              is_last,
  output logic [1:0]        tok_cnt,
  output ctk_pkg::tok_arr_t toks
);
  import ctk_pkg::*;

  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  h0_r, h0_nxt, h1_r, h1_nxt, lc_r, lc_nxt;
  logic [11:0] rl_r, rl_nxt;
  logic [63:0] va_r, va_nxt;
  logic        esc_r, esc_nxt, dots_r, dots_nxt, dok_r, dok_nxt;
  logic [23:0] line_r, line_nxt, tsl_r, tsl_nxt;
  logic [15:0] col_r, col_nxt, tsc_r, tsc_nxt;

  always_comb begin
    logic [3:0]  m;
    logic [7:0]  h0, h1, lc;
    logic [11:0] rl, ci;
    logic [63:0] va, cv;
    logic        esc, dots, dok, do_idle, do_dot, ok;
    logic [23:0] tsl, ln;
    logic [15:0] tsc, cl;
    logic [5:0]  k;
    logic [4:0]  hv;
    logic [12:0] rl1;
    tok_arr_t    q;
    logic [1:0]  n;

    m = mode_r; h0 = h0_r; h1 = h1_r; lc = lc_r; rl = rl_r; va = va_r;
    esc = esc_r; dots = dots_r; dok = dok_r; tsl = tsl_r; tsc = tsc_r;
    ln = line_r; cl = col_r;
    q = '0; n = 2'd0; do_idle = 1'b0; do_dot = 1'b0;
    k = K_UNKNOWN; hv = 5'd0; ok = 1'b1; cv = '0; ci = '0;
    rl1 = {1'b0, rl_r} + 13'd1;

    case (mode_r)
      M_SLASH: begin
        if (b == "*") begin
          m = M_BCOM; rl = 12'd2;
        end else if (b == "/") begin
          m = M_LCOM;
        end else if (b == "=") begin
          q = put(q, n, mk(K_DIV_ASSIGN, 13'd2, '0, tsl, tsc)); n = cnt_inc(n);
          m = M_IDLE;
        end else begin
          q = put(q, n, mk(K_DIV, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
          do_idle = 1'b1;
        end
      end
      M_LCOM: begin
        if (b == 8'h0A) m = M_IDLE;
      end
      M_BCOM, M_BSTAR: begin
        if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        if (mode_r == M_BSTAR && b == "/") m = M_IDLE;
        else m = (b == "*") ? M_BSTAR : M_BCOM;
      end
      M_IDENT: begin
        if (is_word(b)) begin
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end else begin
          q = put(q, n, mk(K_IDENT, {1'b0, rl}, '0, tsl, tsc)); n = cnt_inc(n);
          do_idle = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(b)) begin
          if (!dots) va = (va << 3) + (va << 1) + 64'(b - 8'h30);
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end else if (b == ".") begin
          dots = 1'b1;
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end else if (is_alpha(b)) begin
          m = M_SUFFIX;
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end else begin
          q = put(q, n, mk(K_NUMBER, {1'b0, rl}, va, tsl, tsc)); n = cnt_inc(n);
          do_idle = 1'b1;
        end
      end
      M_SUFFIX: begin
        if (is_word(b)) begin
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end else begin
          q = put(q, n, mk(K_NUMBER, {1'b0, rl}, va, tsl, tsc)); n = cnt_inc(n);
          do_idle = 1'b1;
        end
      end
      M_STR: begin
        if (b == 8'h22) begin
          q = put(q, n, mk(K_STRING, rl1, '0, tsl, tsc)); n = cnt_inc(n);
          m = M_IDLE;
        end else if (rl < 12'(MAX_LEN)) begin
          rl = rl + 12'd1;
        end
      end
      M_CHAR: begin
        ci = rl_r - 12'd1;
        if (!esc_r && b == 8'h27) begin
          // closing quote: decode the literal
          if (ci == 12'd0) begin
            ok = 1'b0;
          end else if (ci == 12'd1) begin
            cv = 64'(h0_r);
          end else if (h0_r != 8'h5C) begin
            cv = 64'(lc_r);
          end else if (ci == 12'd2) begin
            case (h1_r)
              "a": cv = 64'd7;
              "b": cv = 64'd8;
              "f": cv = 64'd12;
              "r": cv = 64'd13;
              "n": cv = 64'd10;
              "t": cv = 64'd9;
              "v": cv = 64'd11;
              8'h5C: cv = 64'd92;
              8'h27: cv = 64'd39;
              8'h22: cv = 64'd34;
              "?": cv = 64'd63;
              default: begin
                if (is_oct(h1_r)) cv = va_r;
                else if (h1_r == "x") cv = '0;
                else ok = 1'b0;
              end
            endcase
          end else if (ci == 12'd3 || ci == 12'd4) begin
            if ((is_oct(h1_r) || h1_r == "x") && dok_r) cv = va_r;
            else ok = 1'b0;
          end else if (ci == 12'd8) begin
            ok = 1'b0;
          end else begin
            cv = 64'(lc_r);
          end
          if (ok) q = put(q, n, mk(K_CHAR, rl1, cv, tsl, tsc));
          else q = put(q, n, mk(K_ERROR, rl1, '0, tsl, tsc));
          n = cnt_inc(n);
          m = M_IDLE;
        end else begin
          if (ci == 12'd0) begin
            h0 = b;
          end else if (ci == 12'd1) begin
            h1 = b;
            va = is_oct(b) ? 64'(b - 8'h30) : '0;
          end else if (h0_r == 8'h5C) begin
            if (is_oct(h1_r)) begin
              if (is_oct(b)) va = (va << 3) + 64'(b - 8'h30);
              else dok = 1'b0;
            end else if (h1_r == "x") begin
              hv = hex_val(b);
              if (!hv[4]) va = (va << 4) + 64'(hv);
              else dok = 1'b0;
            end
          end
          lc = b;
          esc = esc_r ? 1'b0 : (b == 8'h5C);
          if (rl < 12'(MAX_LEN)) rl = rl + 12'd1;
        end
      end
      M_P1: begin
        if ((h0_r == ">" || h0_r == "<") && b == h0_r) begin
          m = M_P2; h1 = b;
        end else begin
          k = pair_kind(h0_r, b);
          if (k != K_UNKNOWN) begin
            q = put(q, n, mk(k, 13'd2, '0, tsl, tsc)); n = cnt_inc(n);
            m = M_IDLE;
          end else begin
            q = put(q, n, mk(lone_kind(h0_r), 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
            do_idle = 1'b1;
          end
        end
      end
      M_DOT: do_dot = 1'b1;
      M_P2: begin
        if (h0_r != ".") begin
          if (b == "=") begin
            q = put(q, n, mk((h0_r == ">") ? K_RSHIFT_ASSIGN : K_LSHIFT_ASSIGN,
                             13'd3, '0, tsl, tsc));
            n = cnt_inc(n);
            m = M_IDLE;
          end else begin
            q = put(q, n, mk((h0_r == ">") ? K_RSHIFT : K_LSHIFT, 13'd2, '0, tsl, tsc));
            n = cnt_inc(n);
            do_idle = 1'b1;
          end
        end else if (b == ".") begin
          q = put(q, n, mk(K_ELLIPSIS, 13'd3, '0, tsl, tsc)); n = cnt_inc(n);
          m = M_IDLE;
        end else if (is_last && !is_space(b) && !is_digit(b)) begin
          q = put(q, n, mk(K_UNKNOWN, 13'd2, '0, tsl, tsc)); n = cnt_inc(n);
          do_idle = 1'b1;
        end else begin
          q = put(q, n, mk(K_DOT, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
          tsc = col_inc(tsc);
          rl = 12'd1;
          m = M_DOT;
          do_dot = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    if (do_dot) begin
      if (is_digit(b)) begin
        m = M_NUM; dots = 1'b1; va = '0; rl = 12'd2;
      end else if (b == ".") begin
        m = M_P2; h0 = "."; h1 = ".";
      end else begin
        q = put(q, n, mk(K_DOT, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
        do_idle = 1'b1;
      end
    end

    // start of a new token at the current byte
    if (do_idle) begin
      m = M_IDLE;
      if (!is_space(b)) begin
        if (b == "/" || is_alpha(b) || is_digit(b) || b == "." || b == 8'h22 ||
            b == 8'h27 || lone_kind(b) != K_UNKNOWN) begin
          tsl = line_r; tsc = col_r; rl = 12'd1; va = '0;
          esc = 1'b0; dots = 1'b0; dok = 1'b1;
          if (b == "/") m = M_SLASH;
          else if (is_alpha(b)) m = M_IDENT;
          else if (is_digit(b)) begin
            m = M_NUM; va = 64'(b - 8'h30);
          end else if (b == ".") m = M_DOT;
          else if (b == 8'h22) m = M_STR;
          else if (b == 8'h27) m = M_CHAR;
          else begin
            m = M_P1; h0 = b;
          end
        end else begin
          q = put(q, n, mk(single_kind(b), 13'd1, '0, line_r, col_r)); n = cnt_inc(n);
        end
      end
    end

    if (b == 8'h0A) begin
      if (ln < LINE_MAX) ln = ln + 24'd1;
      cl = 16'd1;
    end else begin
      cl = col_inc(cl);
    end

    if (is_last) begin
      case (m)
        M_SLASH: begin
          q = put(q, n, mk(K_DIV, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
        end
        M_BCOM, M_BSTAR, M_STR, M_CHAR: begin
          q = put(q, n, mk(K_ERROR, {1'b0, rl}, '0, tsl, tsc)); n = cnt_inc(n);
        end
        M_IDENT: begin
          q = put(q, n, mk(K_IDENT, {1'b0, rl}, '0, tsl, tsc)); n = cnt_inc(n);
        end
        M_NUM, M_SUFFIX: begin
          q = put(q, n, mk(K_NUMBER, {1'b0, rl}, va, tsl, tsc)); n = cnt_inc(n);
        end
        M_P1: begin
          q = put(q, n, mk(lone_kind(h0), 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
        end
        M_DOT: begin
          q = put(q, n, mk(K_DOT, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
        end
        M_P2: begin
          if (h0 == ".") begin
            q = put(q, n, mk(K_DOT, 13'd1, '0, tsl, tsc)); n = cnt_inc(n);
            q = put(q, n, mk(K_DOT, 13'd1, '0, tsl, col_inc(tsc))); n = cnt_inc(n);
          end else begin
            q = put(q, n, mk((h0 == ">") ? K_RSHIFT : K_LSHIFT, 13'd2, '0, tsl, tsc));
            n = cnt_inc(n);
          end
        end
        default: ;
      endcase
      q = put(q, n, mk(K_EOF, 13'd0, '0, ln, cl)); n = cnt_inc(n);
      m = M_IDLE; h0 = '0; h1 = '0; rl = '0; va = '0; esc = 1'b0;
      ln = 24'd1; cl = 16'd1; tsl = 24'd1; tsc = 16'd1;
      dots = 1'b0; dok = 1'b1; lc = '0;
    end

    if (n != 2'd0) q[n - 2'd1].last = 1'b1;

    mode_nxt = m; h0_nxt = h0; h1_nxt = h1; lc_nxt = lc; rl_nxt = rl; va_nxt = va;
    esc_nxt = esc; dots_nxt = dots; dok_nxt = dok; tsl_nxt = tsl; tsc_nxt = tsc;
    line_nxt = ln; col_nxt = cl;
    toks = q;
    tok_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; h0_r <= '0; h1_r <= '0; lc_r <= '0; rl_r <= '0; va_r <= '0;
      esc_r <= 1'b0; dots_r <= 1'b0; dok_r <= 1'b1;
      line_r <= 24'd1; col_r <= 16'd1; tsl_r <= 24'd1; tsc_r <= 16'd1;
    end else if (acc) begin
      mode_r <= mode_nxt; h0_r <= h0_nxt; h1_r <= h1_nxt; lc_r <= lc_nxt;
      rl_r <= rl_nxt; va_r <= va_nxt; esc_r <= esc_nxt; dots_r <= dots_nxt;
      dok_r <= dok_nxt; line_r <= line_nxt; col_r <= col_nxt;
      tsl_r <= tsl_nxt; tsc_r <= tsc_nxt;
    end
  end

endmodule

FILE: hdl/ctk_fifo.sv
// Token queue: takes up to three tokens per cycle, delivers one.
module ctk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        push_cnt,
  input  ctk_pkg::tok_arr_t push_toks,
  input  logic              pop,
  output logic              full3,
  output logic              not_empty,
  output ctk_pkg::tok_t     head
);
  import ctk_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  tok_t          mem [FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [1:0]    n;

  assign n         = push ? push_cnt : 2'd0;
  assign wp_nxt    = wp_r + AW'(n);
  assign rp_nxt    = rp_r + AW'(pop);
  assign cnt_nxt   = cnt_r + (AW + 1)'(n) - (AW + 1)'(pop);
  assign full3     = cnt_r > (AW + 1)'(FIFO_DEPTH - 3);
  assign not_empty = cnt_r != '0;
  assign head      = mem[rp_r];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n) mem[wp_r + AW'(k)] <= push_toks[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/c_source_tokenizer_core.sv
// Top level of the streaming C tokenizer: byte in, tokens out.
// Tokens enter the token queue at their byte's transfer; it throttles in_stall.
// Throughput: one byte per cycle unless in_stall; each byte yields zero to three
// tokens, which drain one per cycle unless out_stall via an eight-entry queue.
// Reset: synchronous active-low rst_n clears the scanner to line 1, column 1
// and empties the queue.
module c_source_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [11:0] out_token_length,
  output logic [63:0] out_token_value,
  output logic [23:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic        out_last_of_run
);
  import ctk_pkg::*;

  logic     acc, full3, pop;
  logic [1:0] cnt;
  tok_arr_t toks;
  tok_t     head;

  // stall while the queue lacks room for a worst-case three-token byte
  assign in_stall = full3;
  assign acc      = in_valid && !full3;
  assign pop      = out_valid && !out_stall;

  ctk_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .b       (in_char_in),
    .is_last (in_is_last),
    .tok_cnt (cnt),
    .toks    (toks)
  );

  ctk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_cnt  (cnt),
    .push_toks (toks),
    .pop       (pop),
    .full3     (full3),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_length = head.len;
  assign out_token_value  = head.value;
  assign out_start_line   = head.line;
  assign out_start_column = head.col;
  assign out_last_of_run  = head.last;

endmodule

FILE: bench/tb_c_source_tokenizer_core.sv
// Self-checking bench for the streaming C tokenizer: directed table, then random C-like text.
`timescale 1ns / 1ps

module tb_c_source_tokenizer_core;
  import ctk_pkg::*;

  // one expected token
  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] len;
    logic [63:0] value;
    logic [23:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  // directed row: byte, end flag, and optionally the first token it must cause
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       has_tok;
    token_t     tok;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [11:0] out_token_length;
  logic [63:0] out_token_value;
  logic [23:0] out_start_line;
  logic [15:0] out_start_column;
  logic        out_last_of_run;

  c_source_tokenizer_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_in, .in_is_last,
    .out_valid, .out_stall, .out_token_kind, .out_token_length, .out_token_value,
    .out_start_line, .out_start_column, .out_last_of_run
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scanner model: its own copy of the lexer state
  // ---------------------------------------------------------------------------
  logic [3:0]  lx_mode;
  logic [7:0]  lx_held0, lx_held1;
  int unsigned lx_run;
  logic [63:0] lx_acc;
  logic        lx_esc, lx_dot, lx_digok;
  logic [7:0]  lx_lastc;
  logic [23:0] lx_line, lx_tline;
  logic [15:0] lx_col, lx_tcol;

  token_t step_toks[$];     // tokens of the byte being modeled
  token_t pending_toks[$];  // tokens waiting to appear on out_

  int  errors;

  function automatic void lex_clear();
    lx_mode = M_IDLE; lx_held0 = 8'd0; lx_held1 = 8'd0; lx_run = 0; lx_acc = 64'd0;
    lx_esc = 1'b0; lx_line = 24'd1; lx_col = 16'd1; lx_tline = 24'd1; lx_tcol = 16'd1;
    lx_dot = 1'b0; lx_digok = 1'b1; lx_lastc = 8'd0;
  endfunction

  function automatic void push_tok(logic [5:0] k, int unsigned len, logic [63:0] v,
                                   logic [23:0] l, logic [15:0] c);
    token_t t;
    if (step_toks.size() >= 3) return;
    t.kind = k;
    t.len = (len > MAX_LEN) ? 12'(MAX_LEN) : 12'(len);
    t.value = v; t.line = l; t.col = c; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void tok_here(logic [5:0] k, int unsigned len, logic [63:0] v);
    push_tok(k, len, v, lx_tline, lx_tcol);
  endfunction

  function automatic void grow();
    if (lx_run < MAX_LEN) lx_run++;
  endfunction

  function automatic logic [5:0] op1_kind(logic [7:0] h);
    case (h)
      "+": return 6'd5;   "-": return 6'd6;   "*": return 6'd7;   "%": return 6'd9;
      "=": return 6'd17;  ">": return 6'd18;  "<": return 6'd19;  "!": return 6'd24;
      "&": return 6'd27;  "~": return 6'd28;  "|": return 6'd29;  "^": return 6'd30;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [5:0] op2_kind(logic [7:0] h, logic [7:0] b);
    if (b == "=") begin
      case (h)
        "+": return 6'd10;  "-": return 6'd11;  "*": return 6'd12;  "%": return 6'd14;
        "=": return 6'd22;  ">": return 6'd20;  "<": return 6'd21;  "!": return 6'd23;
        "&": return 6'd33;  "~": return 6'd34;  "|": return 6'd35;  "^": return 6'd36;
        default: return K_UNKNOWN;
      endcase
    end
    if (h == b) begin
      case (h)
        "+": return 6'd15;  "-": return 6'd16;  "&": return 6'd25;  "|": return 6'd26;
        default: return K_UNKNOWN;
      endcase
    end
    if (h == "-" && b == ">") return 6'd46;
    return K_UNKNOWN;
  endfunction

  function automatic logic [5:0] sep_kind(logic [7:0] b);
    case (b)
      "(": return 6'd39;  ")": return 6'd40;  "[": return 6'd41;  "]": return 6'd42;
      "{": return 6'd43;  "}": return 6'd44;  ";": return 6'd47;  ":": return 6'd48;
      ",": return 6'd49;  "?": return 6'd51;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic c_digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
  function automatic logic c_oct(logic [7:0] b);   return b >= "0" && b <= "7"; endfunction
  function automatic logic c_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction
  function automatic logic c_space(logic [7:0] b);
    return b == 8'h20 || b == 8'h0A || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic int hexdig(logic [7:0] b);
    if (c_digit(b)) return b - 8'h30;
    if (b >= "a" && b <= "f") return b - 8'h57;
    if (b >= "A" && b <= "F") return b - 8'h37;
    return 16;
  endfunction

  function automatic void open_tok(logic [3:0] m, logic [23:0] l, logic [15:0] c);
    lx_mode = m; lx_tline = l; lx_tcol = c; lx_run = 1; lx_acc = 64'd0;
    lx_esc = 1'b0; lx_dot = 1'b0; lx_digok = 1'b1;
  endfunction

  function automatic void start_byte(logic [7:0] b, logic [23:0] l, logic [15:0] c);
    lx_mode = M_IDLE;
    if (c_space(b)) return;
    if (b == "/") open_tok(M_SLASH, l, c);
    else if (c_alpha(b)) open_tok(M_IDENT, l, c);
    else if (c_digit(b)) begin
      open_tok(M_NUM, l, c);
      lx_acc = 64'(b - 8'h30);
    end else if (b == ".") open_tok(M_DOT, l, c);
    else if (b == "\"") open_tok(M_STR, l, c);
    else if (b == "'") open_tok(M_CHAR, l, c);
    else if (op1_kind(b) != K_UNKNOWN) begin
      open_tok(M_P1, l, c);
      lx_held0 = b;
    end else push_tok(sep_kind(b), 1, 64'd0, l, c);
  endfunction

  function automatic void after_dot(logic [7:0] b, logic [23:0] l, logic [15:0] c);
    if (c_digit(b)) begin
      lx_mode = M_NUM; lx_dot = 1'b1; lx_acc = 64'd0; lx_run = 2;
    end else if (b == ".") begin
      lx_mode = M_P2; lx_held0 = "."; lx_held1 = ".";
    end else begin
      tok_here(K_DOT, 1, 64'd0);
      start_byte(b, l, c);
    end
  endfunction

  function automatic void char_body(logic [7:0] b);
    int unsigned i;
    int hv;
    i = lx_run - 1;
    if (i == 0) lx_held0 = b;
    else if (i == 1) begin
      lx_held1 = b;
      lx_acc = c_oct(b) ? 64'(b - 8'h30) : 64'd0;
    end else if (lx_held0 == "\\") begin
      if (c_oct(lx_held1)) begin
        if (c_oct(b)) lx_acc = lx_acc * 8 + 64'(b - 8'h30);
        else lx_digok = 1'b0;
      end else if (lx_held1 == "x") begin
        hv = hexdig(b);
        if (hv < 16) lx_acc = lx_acc * 16 + 64'(hv);
        else lx_digok = 1'b0;
      end
    end
    lx_lastc = b;
    lx_esc = lx_esc ? 1'b0 : (b == "\\");
    grow();
  endfunction

  function automatic void char_close();
    int unsigned n;
    logic [63:0] v;
    logic ok;
    n = lx_run - 1; v = 64'd0; ok = 1'b1;
    if (n == 0) ok = 1'b0;
    else if (n == 1) v = 64'(lx_held0);
    else if (lx_held0 != "\\") v = 64'(lx_lastc);
    else if (n == 2) begin
      case (lx_held1)
        "a": v = 7;   "b": v = 8;   "f": v = 12;  "r": v = 13;
        "n": v = 10;  "t": v = 9;   "v": v = 11;  "\\": v = 92;
        "'": v = 39;  "\"": v = 34; "?": v = 63;
        default: begin
          if (c_oct(lx_held1)) v = lx_acc;
          else if (lx_held1 == "x") v = 64'd0;
          else ok = 1'b0;
        end
      endcase
    end else if (n == 3 || n == 4) begin
      if ((c_oct(lx_held1) || lx_held1 == "x") && lx_digok) v = lx_acc;
      else ok = 1'b0;
    end else if (n == 8) ok = 1'b0;
    else v = 64'(lx_lastc);
    if (ok) tok_here(K_CHAR, lx_run + 1, v);
    else tok_here(K_ERROR, lx_run + 1, 64'd0);
    lx_mode = M_IDLE;
  endfunction

  function automatic void scan_byte(logic [7:0] b, logic [23:0] l, logic [15:0] c, logic fin);
    logic [7:0] h;
    logic [5:0] k;
    h = lx_held0;
    case (lx_mode)
      M_SLASH: begin
        if (b == "*") begin lx_mode = M_BCOM; lx_run = 2; end
        else if (b == "/") lx_mode = M_LCOM;
        else if (b == "=") begin tok_here(K_DIV_ASSIGN, 2, 64'd0); lx_mode = M_IDLE; end
        else begin tok_here(K_DIV, 1, 64'd0); start_byte(b, l, c); end
      end
      M_LCOM: if (b == 8'h0A) lx_mode = M_IDLE;
      M_BCOM, M_BSTAR: begin
        grow();
        if (lx_mode == M_BSTAR && b == "/") lx_mode = M_IDLE;
        else lx_mode = (b == "*") ? M_BSTAR : M_BCOM;
      end
      M_IDENT: begin
        if (c_alpha(b) || c_digit(b)) grow();
        else begin tok_here(K_IDENT, lx_run, 64'd0); start_byte(b, l, c); end
      end
      M_NUM: begin
        if (c_digit(b)) begin
          if (!lx_dot) lx_acc = lx_acc * 10 + 64'(b - 8'h30);
          grow();
        end else if (b == ".") begin lx_dot = 1'b1; grow(); end
        else if (c_alpha(b)) begin lx_mode = M_SUFFIX; grow(); end
        else begin tok_here(K_NUMBER, lx_run, lx_acc); start_byte(b, l, c); end
      end
      M_SUFFIX: begin
        if (c_alpha(b) || c_digit(b)) grow();
        else begin tok_here(K_NUMBER, lx_run, lx_acc); start_byte(b, l, c); end
      end
      M_STR: begin
        if (b == "\"") begin tok_here(K_STRING, lx_run + 1, 64'd0); lx_mode = M_IDLE; end
        else grow();
      end
      M_CHAR: begin
        if (!lx_esc && b == "'") char_close();
        else char_body(b);
      end
      M_P1: begin
        if ((h == ">" || h == "<") && b == h) begin
          lx_mode = M_P2; lx_held1 = b;
        end else begin
          k = op2_kind(h, b);
          if (k != K_UNKNOWN) begin tok_here(k, 2, 64'd0); lx_mode = M_IDLE; end
          else begin tok_here(op1_kind(h), 1, 64'd0); start_byte(b, l, c); end
        end
      end
      M_DOT: after_dot(b, l, c);
      M_P2: begin
        if (h != ".") begin
          if (b == "=") begin
            tok_here(h == ">" ? K_RSHIFT_ASSIGN : K_LSHIFT_ASSIGN, 3, 64'd0);
            lx_mode = M_IDLE;
          end else begin
            tok_here(h == ">" ? K_RSHIFT : K_LSHIFT, 2, 64'd0);
            start_byte(b, l, c);
          end
        end else if (b == ".") begin
          tok_here(K_ELLIPSIS, 3, 64'd0);
          lx_mode = M_IDLE;
        end else if (fin && !c_space(b) && !c_digit(b)) begin
          // stray dot pair at end of input: one unknown token of length two
          tok_here(K_UNKNOWN, 2, 64'd0);
          start_byte(b, l, c);
        end else begin
          tok_here(K_DOT, 1, 64'd0);
          lx_tcol = col_inc(lx_tcol);
          lx_run = 1;
          lx_mode = M_DOT;
          after_dot(b, l, c);
        end
      end
      default: start_byte(b, l, c);
    endcase
  endfunction

  function automatic void drain_at_end();
    case (lx_mode)
      M_SLASH: tok_here(K_DIV, 1, 64'd0);
      M_BCOM, M_BSTAR, M_STR, M_CHAR: tok_here(K_ERROR, lx_run, 64'd0);
      M_IDENT: tok_here(K_IDENT, lx_run, 64'd0);
      M_NUM, M_SUFFIX: tok_here(K_NUMBER, lx_run, lx_acc);
      M_P1: tok_here(op1_kind(lx_held0), 1, 64'd0);
      M_DOT: tok_here(K_DOT, 1, 64'd0);
      M_P2: begin
        if (lx_held0 == ".") begin
          tok_here(K_DOT, 1, 64'd0);
          push_tok(K_DOT, 1, 64'd0, lx_tline, col_inc(lx_tcol));
        end else tok_here(lx_held0 == ">" ? K_RSHIFT : K_LSHIFT, 2, 64'd0);
      end
      default: ;
    endcase
    lx_mode = M_IDLE;
  endfunction

  // models one accepted byte and appends its tokens to the expected store
  function automatic void tokenize_byte(logic [7:0] b, logic fin);
    step_toks.delete();
    scan_byte(b, lx_line, lx_col, fin);
    if (b == 8'h0A) begin
      if (lx_line < LINE_MAX) lx_line++;
      lx_col = 16'd1;
    end else lx_col = col_inc(lx_col);
    if (fin) begin
      drain_at_end();
      push_tok(K_EOF, 0, 64'd0, lx_line, lx_col);
      lex_clear();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) pending_toks.push_back(step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Idling control and the input feed
  // ---------------------------------------------------------------------------
  int send_idle_pct, recv_stall_pct;
  bit hold_recv;        // long receiver hold-off in progress
  longint n_accepted;   // input transfers so far
  longint n_tokens;     // output transfers so far
  row_t   row_q[$];     // directed rows that carry an expected token

  // drives one byte and waits for its transfer; the model runs at acceptance.
  // valid stays up on return so the next byte can follow without a gap.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= b;
    in_is_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(b, fin);
    n_accepted++;
    @(negedge clk);
  endtask

  // sends text as a byte stream; mark_end sets the end flag on the final byte
  task automatic send_text(input string s, input bit mark_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], mark_end && (i == s.len() - 1));
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    while (pending_toks.size() != 0) @(negedge clk);
  endtask

  // random C-like fragment: mostly well-formed lexemes, some noise
  function automatic string rand_frag();
    string ops[] = '{"+","-","*","/","%","+=","-=","*=","/=","%=","++","--","=",">","<",
                     ">=","<=","==","!=","!","&&","||","&","~","|","^","<<",">>","&=","~=",
                     "|=","^=","<<=",">>=","(",")","[","]","{","}",".","->",";",":",",",
                     "...","?"};
    string esc[] = '{"\\n","\\t","\\0","\\x4F","\\101","\\'","\\\\","\\q","\\x","\\7",
                     "\\xZ1","\\18"};
    string s;
    int n;
    s = "";
    case ($urandom_range(11))
      0, 1: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, string'(byte'(c_pick_word(i == 0)))};
      end
      2: begin
        n = $urandom_range(1, ($urandom_range(9) == 0) ? 22 : 5);
        for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
        if ($urandom_range(3) == 0) s = {s, ".5"};
        if ($urandom_range(3) == 0) s = {s, "uL"};
      end
      3, 4: s = ops[$urandom_range(ops.size() - 1)];
      5: s = {"\"ab", string'(byte'($urandom_range(32, 126) == 34 ? 65 : 66)), "\""};
      6: begin
        if ($urandom_range(1)) s = {"'", string'(byte'($urandom_range(65, 90))), "'"};
        else s = {"'", esc[$urandom_range(esc.size() - 1)], "'"};
      end
      7: s = ($urandom_range(1)) ? "/* c*/" : "// x\n";
      8: s = ($urandom_range(1)) ? "\n" : "\t";
      9: s = "..";
      10: s = string'(byte'($urandom_range(128, 255)));
      default: s = string'(byte'($urandom_range(1, 127)));
    endcase
    return s;
  endfunction

  function automatic byte c_pick_word(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return byte'("a" + r);
    if (r < 52) return byte'("A" + r - 26);
    if (r == 52) return "_";
    return byte'("0" + r - 53);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall, long hold-off, and checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    token_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      n_tokens++;
      got = '{out_token_kind, out_token_length, out_token_value, out_start_line,
              out_start_column, out_last_of_run};
      if (pending_toks.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, actual %h", $realtime, got);
      end else begin
        want = pending_toks.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: token mismatch, expected kind %0d len %0d val %0d line %0d col %0d last %0d, actual kind %0d len %0d val %0d line %0d col %0d last %0d",
                   $realtime, want.kind, want.len, want.value, want.line, want.col, want.last,
                   got.kind, got.len, got.value, got.line, got.col, got.last);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: checked rows carry the first token the byte must cause
  // ---------------------------------------------------------------------------
  row_t dir_rows[$];

  function automatic void add_row(logic [7:0] ch, logic fin, logic has, token_t t);
    row_t r;
    r.ch = ch; r.fin = fin; r.has_tok = has; r.tok = t;
    dir_rows.push_back(r);
  endfunction

  function automatic token_t mk_tok(logic [5:0] k, int len, logic [63:0] v, int l, int c,
                                    logic last);
    token_t t;
    t = '{k, 12'(len), v, 24'(l), 16'(c), last};
    return t;
  endfunction

  initial begin
    string frag;
    int phase;
    errors = 0; n_accepted = 0; n_tokens = 0; hold_recv = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_char_in = 8'd0; in_is_last = 1'b0; out_stall = 1'b0;
    lex_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // right after reset: NUL is an unknown token at line 1 column 1
    add_row(8'h00, 1'b0, 1'b1, mk_tok(K_UNKNOWN, 1, 0, 1, 1, 1'b1));
    add_row(8'hFF, 1'b0, 1'b1, mk_tok(K_UNKNOWN, 1, 0, 1, 2, 1'b1));
    add_row("9", 1'b0, 1'b0, '0);
    add_row(">", 1'b0, 1'b1, mk_tok(K_NUMBER, 1, 9, 1, 3, 1'b1));
    add_row(">", 1'b0, 1'b0, '0);
    add_row("=", 1'b0, 1'b1, mk_tok(K_RSHIFT_ASSIGN, 3, 0, 1, 4, 1'b1));
    add_row(".", 1'b0, 1'b0, '0);
    add_row(".", 1'b0, 1'b0, '0);
    add_row(".", 1'b0, 1'b1, mk_tok(K_ELLIPSIS, 3, 0, 1, 7, 1'b1));
    add_row("'", 1'b0, 1'b0, '0);
    add_row("'", 1'b0, 1'b1, mk_tok(K_ERROR, 2, 0, 1, 10, 1'b1));   // empty char
    add_row("\"", 1'b0, 1'b0, '0);
    add_row("x", 1'b1, 1'b1, mk_tok(K_ERROR, 2, 0, 1, 12, 1'b0));   // open string at end
    // stray dot pair before a final letter
    add_row(".", 1'b0, 1'b0, '0);
    add_row(".", 1'b0, 1'b0, '0);
    add_row("a", 1'b1, 1'b1, mk_tok(K_UNKNOWN, 2, 0, 1, 1, 1'b0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_tok) row_q.push_back(dir_rows[i]);
      // the first new token must equal the typed row value
      if (dir_rows[i].has_tok) begin
        send_byte(dir_rows[i].ch, dir_rows[i].fin);
        if (step_toks.size() == 0 || step_toks[0] !== dir_rows[i].tok) begin
          errors++;
          $display("%0t: directed row %0d, expected %h, actual model %h", $realtime, i,
                   dir_rows[i].tok, step_toks.size() ? step_toks[0] : '0);
        end
      end else send_byte(dir_rows[i].ch, dir_rows[i].fin);
    end
    // every punctuator form, char escapes, comments, open comment at end
    send_text("+ - * / % += -= *= /= %= ++ -- = > < >= <= == != ! && || & ~ | ^ ", 0);
    send_text("<< >> &= ~= |= ^= <<= >>= ( ) [ ] { } . -> ; : , ? .5 .. 1..", 0);
    send_text("'\\n' '\\x41' '\\101' '\\q' 'ab' '\\1234567' // c\n/* * */\"s\" 18446744073709551617", 0);
    send_text("\n/* open", 1);
    wait_empty();

    // random part in idling phases
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 4) begin
        // long receiver hold-off while bytes keep coming: the queue fills up
        fork
          begin
            hold_recv = 1'b1;
            repeat (60) @(negedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 15; ) begin
        frag = rand_frag();
        send_text(frag, 0);
        n += frag.len();
        send_byte(($urandom_range(2) == 0) ? 8'h0A : 8'h20, ($urandom_range(15) == 0));
      end
      // sender pauses until every expected token has come
      send_byte(";", 1'b1);
      wait_empty();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && pending_toks.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
